@@ hdl/rc5_pkg.sv @@
// Shared types and constants for the RC5-32 OFB cipher unit.
// No dependencies; imported by the core and the top level.
package rc5_pkg;

  // Key schedule magic constants for 32-bit words.
  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  // Operating modes carried with each block.
  localparam logic [1:0] MODE_ENC  = 2'd0;
  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_OFB  = 2'd2;
  localparam logic [1:0] MODE_PASS = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_ROUNDS   = 2'd2;
  localparam logic [1:0] REG_IV       = 2'd3;

  localparam logic [5:0] ROUNDS_RESET = 6'd12;

  // Configuration handed from the register file to the core.
  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [5:0]  round_count;
    logic [63:0] init_vector;
  } cfg_t;

  // Rotate left; an amount of zero returns the operand.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  // Rotate right; an amount of zero returns the operand.
  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

endpackage

@@ hdl/rc5_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the subkey table of the cipher core.
module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 66
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/rc5_core.sv @@
// RC5-32 sequencer: key schedule, shared half-round unit, keystream and result register.
// Depends on rc5_pkg and rc5_ram (subkey table).
module rc5_core #(
  parameter int MAX_ROUNDS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rc5_pkg::cfg_t cfg,
  input  logic          cfg_clear,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_mode,
  input  logic [31:0]   in_half_a,
  input  logic [31:0]   in_half_b,
  input  logic          in_restart,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_a,
  output logic [31:0]   out_b
);
  import rc5_pkg::*;

  localparam int TD = 2 * MAX_ROUNDS + 2;
  localparam int AW = $clog2(TD);
  localparam int TW = AW + 1;
  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int SW = $clog2(6 * MAX_ROUNDS + 7);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL   = 3'd1;
  localparam logic [2:0] ST_MIXPRE = 3'd2;
  localparam logic [2:0] ST_MIXA   = 3'd3;
  localparam logic [2:0] ST_MIXB   = 3'd4;
  localparam logic [2:0] ST_CPRE   = 3'd5;
  localparam logic [2:0] ST_CRUN   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic          ready_r, ready_nxt;
  logic [63:0]   ks_r, ks_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [31:0]   xa_r, xa_nxt, xb_r, xb_nxt;
  logic [31:0]   da_r, da_nxt, db_r, db_nxt;
  logic [31:0]   ma_r, ma_nxt, mb_r, mb_nxt;
  logic [31:0]   fill_r, fill_nxt;
  logic [31:0]   kw_r [4];
  logic [31:0]   kw_nxt [4];
  logic [AW-1:0] i_r, i_nxt;
  logic [1:0]    j_r, j_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [TW-1:0] hc_r, hc_nxt;
  logic          ov_r, ov_nxt;
  logic [31:0]   oa_r, oa_nxt, ob_r, ob_nxt;

  logic [RW-1:0] r_eff;
  logic [TW-1:0] t_val;
  logic [TW-1:0] i_inc;
  logic [AW-1:0] i_wrap;
  logic [AW-1:0] k_start;
  logic [AW-1:0] k_step;
  logic          dir_dec;
  logic          we;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [31:0]   a_mix, sum_ab, b_mix;
  logic          out_free;
  logic          accept;

  // Subkey table.
  rc5_ram #(.WIDTH(32), .DEPTH(TD)) u_subkeys (
    .clk   (clk),
    .we    (we),
    .waddr (i_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Effective round count, clamped to the supported range, and table size.
  always_comb begin
    if (cfg.round_count == 6'd0) begin
      r_eff = RW'(1);
    end else if (32'(cfg.round_count) > MAX_ROUNDS) begin
      r_eff = RW'(MAX_ROUNDS);
    end else begin
      r_eff = RW'(cfg.round_count);
    end
  end
  assign t_val = {1'b0, r_eff, 1'b0} + TW'(2);

  // Table index stepping with wrap at the table size.
  assign i_inc   = TW'(i_r) + TW'(1);
  assign i_wrap  = (i_inc == t_val) ? '0 : i_inc[AW-1:0];
  assign dir_dec = (mode_r == MODE_DEC);
  assign k_start = dir_dec ? AW'(t_val - TW'(1)) : '0;
  assign k_step  = dir_dec ? (k_r - AW'(1)) : (k_r + AW'(1));

  // Key mixing arithmetic: subkey update, then key word update.
  assign a_mix  = rotl32(rdata + ma_r + mb_r, 5'd3);
  assign sum_ab = ma_r + mb_r;
  assign b_mix  = rotl32(kw_r[j_r] + sum_ab, sum_ab[4:0]);

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_a     = oa_r;
  assign out_b     = ob_r;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    ks_nxt    = ks_r;
    mode_nxt  = mode_r;
    xa_nxt    = xa_r;
    xb_nxt    = xb_r;
    da_nxt    = da_r;
    db_nxt    = db_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    fill_nxt  = fill_r;
    kw_nxt    = kw_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    steps_nxt = steps_r;
    k_nxt     = k_r;
    hc_nxt    = hc_r;
    ov_nxt    = ov_r && !out_ready;
    oa_nxt    = oa_r;
    ob_nxt    = ob_r;
    we        = 1'b0;
    wdata     = fill_r;
    raddr     = i_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt = in_mode;
          da_nxt   = in_half_a;
          db_nxt   = in_half_b;
          if (in_mode == MODE_OFB) begin
            xa_nxt = in_restart ? cfg.init_vector[31:0]  : ks_r[31:0];
            xb_nxt = in_restart ? cfg.init_vector[63:32] : ks_r[63:32];
          end else begin
            xa_nxt = in_half_a;
            xb_nxt = in_half_b;
          end
          if (!ready_r) begin
            kw_nxt[0] = cfg.key_low[31:0];
            kw_nxt[1] = cfg.key_low[63:32];
            kw_nxt[2] = cfg.key_high[31:0];
            kw_nxt[3] = cfg.key_high[63:32];
            fill_nxt  = MAGIC_P;
            i_nxt     = '0;
            state_nxt = ST_FILL;
          end else if (in_mode == MODE_PASS) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CPRE;
          end
        end
      end
      ST_FILL: begin
        // Arithmetic progression of the magic constants.
        we       = 1'b1;
        wdata    = fill_r;
        fill_nxt = fill_r + MAGIC_Q;
        i_nxt    = i_wrap;
        if (i_inc == t_val) begin
          ma_nxt    = '0;
          mb_nxt    = '0;
          j_nxt     = '0;
          steps_nxt = SW'(t_val) + SW'({t_val, 1'b0});
          state_nxt = ST_MIXPRE;
        end
      end
      ST_MIXPRE: begin
        raddr     = i_r;
        state_nxt = ST_MIXA;
      end
      ST_MIXA: begin
        we        = 1'b1;
        wdata     = a_mix;
        ma_nxt    = a_mix;
        state_nxt = ST_MIXB;
      end
      ST_MIXB: begin
        kw_nxt[j_r] = b_mix;
        mb_nxt      = b_mix;
        i_nxt       = i_wrap;
        j_nxt       = j_r + 2'd1;
        steps_nxt   = steps_r - SW'(1);
        raddr       = i_wrap;
        if (steps_r == SW'(1)) begin
          ready_nxt = 1'b1;
          state_nxt = (mode_r == MODE_PASS) ? ST_DONE : ST_CPRE;
        end else begin
          state_nxt = ST_MIXA;
        end
      end
      ST_CPRE: begin
        raddr     = k_start;
        k_nxt     = k_start;
        hc_nxt    = t_val - TW'(1);
        state_nxt = ST_CRUN;
      end
      ST_CRUN: begin
        // One half-round per cycle on the subkey that arrives now.
        if (!dir_dec) begin
          if (k_r[AW-1:1] == '0) begin
            if (k_r[0]) xb_nxt = xb_r + rdata;
            else        xa_nxt = xa_r + rdata;
          end else if (k_r[0]) begin
            xb_nxt = rotl32(xb_r ^ xa_r, xa_r[4:0]) + rdata;
          end else begin
            xa_nxt = rotl32(xa_r ^ xb_r, xb_r[4:0]) + rdata;
          end
        end else begin
          if (k_r[AW-1:1] == '0) begin
            if (k_r[0]) xb_nxt = xb_r - rdata;
            else        xa_nxt = xa_r - rdata;
          end else if (k_r[0]) begin
            xb_nxt = rotr32(xb_r - rdata, xa_r[4:0]) ^ xa_r;
          end else begin
            xa_nxt = rotr32(xa_r - rdata, xb_r[4:0]) ^ xb_r;
          end
        end
        if (hc_r == '0) begin
          raddr     = k_r;
          state_nxt = ST_DONE;
        end else begin
          raddr  = k_step;
          k_nxt  = k_step;
          hc_nxt = hc_r - TW'(1);
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          ov_nxt = 1'b1;
          if (mode_r == MODE_OFB) begin
            oa_nxt = xa_r ^ da_r;
            ob_nxt = xb_r ^ db_r;
            ks_nxt = {xb_r, xa_r};
          end else begin
            oa_nxt = xa_r;
            ob_nxt = xb_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A configuration write invalidates the schedule.
    if (cfg_clear) begin
      ready_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
      ks_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      ks_r    <= ks_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    xa_r    <= xa_nxt;
    xb_r    <= xb_nxt;
    da_r    <= da_nxt;
    db_r    <= db_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    fill_r  <= fill_nxt;
    kw_r    <= kw_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    steps_r <= steps_nxt;
    k_r     <= k_nxt;
    hc_r    <= hc_nxt;
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
  end

endmodule

@@ hdl/rc5_block_cipher_ofb_unit.sv @@
// RC5-32 block cipher unit with encrypt, decrypt and OFB modes.
// Each block is processed at one half-round per cycle on the subkey RAM read port; a new
// block is taken only after the previous result has moved to the output register.
// A pass-through block (mode 3) skips the rounds. A result that waits on out_ready stalls
// the next block. After reset or a register write the first block runs the key schedule.
// Reset (rst_n low, synchronous) restores register defaults, zeroes the keystream and
// marks the schedule invalid; the subkey RAM is not cleared.
module rc5_block_cipher_ofb_unit #(
  parameter int MAX_ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_half_a,
  input  logic [31:0] in_half_b,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_a,
  output logic [31:0] out_b
);
  import rc5_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  // Register file write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_KEY_LOW:  cfg_nxt.key_low     = pwdata;
        REG_KEY_HIGH: cfg_nxt.key_high    = pwdata;
        REG_ROUNDS:   cfg_nxt.round_count = pwdata[5:0];
        REG_IV:       cfg_nxt.init_vector = pwdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_low     <= '0;
      cfg_r.key_high    <= '0;
      cfg_r.round_count <= ROUNDS_RESET;
      cfg_r.init_vector <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back of the selected register.
  always_comb begin
    case (reg_idx)
      REG_KEY_LOW:  prdata = cfg_r.key_low;
      REG_KEY_HIGH: prdata = cfg_r.key_high;
      REG_ROUNDS:   prdata = {58'd0, cfg_r.round_count};
      REG_IV:       prdata = cfg_r.init_vector;
      default:      prdata = '0;
    endcase
  end

  // Cipher core; every register write invalidates its key schedule.
  rc5_core #(.MAX_ROUNDS(MAX_ROUNDS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cfg_clear  (wr_en),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_half_a  (in_half_a),
    .in_half_b  (in_half_b),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_a      (out_a),
    .out_b      (out_b)
  );

endmodule
